// File: design/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg: shared definitions for the button debounce and press classifier
// Holds register indexes, field widths, reset values and the config struct.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  // Width of the two threshold registers.
  localparam int THRESH_W = 16;
  // Width of the register index on the configuration channel.
  localparam int CFG_INDEX_W = 8;

  // Default width of the settle and hold counters.
  localparam int COUNT_WIDTH_DEFAULT = 16;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TICKS = CFG_INDEX_W'(1);

  // Reset values of the registers.
  localparam logic [THRESH_W-1:0] DEBOUNCE_TICKS_RESET   = THRESH_W'(30);
  localparam logic [THRESH_W-1:0] LONG_PRESS_TICKS_RESET = THRESH_W'(3000);

  // Both thresholds, handed from the register file to the classifier.
  typedef struct packed {
    logic [THRESH_W-1:0] debounce_ticks;
    logic [THRESH_W-1:0] long_press_ticks;
  } bdpc_cfg_t;

endpackage

// File: design/bdpc_in_if.sv
// ----------------------------------------------------------------------------
// bdpc_in_if: button sample channel
// Carries one sampled, active-low button level per item.
// ----------------------------------------------------------------------------
interface bdpc_in_if;
  logic valid;
  logic ready;
  logic level;

  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

// File: design/bdpc_out_if.sv
// ----------------------------------------------------------------------------
// bdpc_out_if: classifier result channel
// Carries the debounced pressed state and the short and long press pulses.
// ----------------------------------------------------------------------------
interface bdpc_out_if;
  logic valid;
  logic ready;
  logic is_pressed;
  logic short_press;
  logic long_press;

  modport source (output valid, output is_pressed, output short_press,
                  output long_press, input ready);
  modport sink (input valid, input is_pressed, input short_press,
                input long_press, output ready);
endinterface

// File: design/bdpc_cfg_if.sv
// ----------------------------------------------------------------------------
// bdpc_cfg_if: configuration write channel
// Carries a register index and the data to be written there.
// ----------------------------------------------------------------------------
interface bdpc_cfg_if import bdpc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [THRESH_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/button_debounce_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_unit: debounced button with short/long press
// Top level: sample input register, threshold registers and the classifier.
// ----------------------------------------------------------------------------
// Each item on the button channel is one tick carrying the active-low pin
// level, and each tick yields exactly one result item with the debounced
// pressed state and two one-tick pulses, short_press and long_press. A new
// level must repeat for debounce_ticks ticks before it is taken as stable; a
// stable press that is released before long_press_ticks reports a short press,
// and a hold that reaches long_press_ticks reports a long press once. Both
// thresholds come out of reset at 30 and 3000 ticks and are written through
// the cfg channel (index 0 and 1, other indexes are ignored); the user must
// write them only while the block is idle, which the block does not enforce.
// The block takes one item every clock cycle while the result channel keeps
// taking items: the item is captured in an input register and the whole
// state update is combinational logic into the result register. A stalled
// result holds both stages; while it waits, the input register takes a
// next item only if empty. The settle and hold counters are COUNT_WIDTH
// bits wide and saturate; a threshold above their range is never reached.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_unit import bdpc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  bdpc_in_if.sink    button,
  bdpc_out_if.source result,
  bdpc_cfg_if.sink   cfg
);

  bdpc_cfg_t cfg_regs;

  // Input register stage.
  logic stage_valid;
  logic stage_level;
  logic take;

  // The input register frees up whenever the classifier consumes it.
  assign button.ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (button.ready) begin
      stage_valid <= button.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (button.valid && button.ready) begin
      stage_level <= button.level;
    end
  end

  bdpc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  bdpc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_regs   (cfg_regs),
    .item_valid (stage_valid),
    .item_level (stage_level),
    .take       (take),
    .result     (result)
  );

endmodule

// File: design/bdpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdpc_cfg_regs: threshold register file
// Takes writes from the configuration channel; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bdpc_cfg_regs import bdpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bdpc_cfg_if.sink   cfg,
  output bdpc_cfg_t  regs
);

  logic [THRESH_W-1:0] debounce_ticks;
  logic [THRESH_W-1:0] long_press_ticks;

  // Writes complete in the cycle they are offered.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_TICKS_RESET;
      long_press_ticks <= LONG_PRESS_TICKS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_DEBOUNCE_TICKS) begin
        debounce_ticks <= cfg.data;
      end
      if (cfg.index == REG_LONG_PRESS_TICKS) begin
        long_press_ticks <= cfg.data;
      end
    end
  end

  assign regs.debounce_ticks   = debounce_ticks;
  assign regs.long_press_ticks = long_press_ticks;

endmodule

// File: design/bdpc_core.sv
// ----------------------------------------------------------------------------
// bdpc_core: debounce and press classification with result register
// Updates the debounce and press state once per item and registers the result.
// ----------------------------------------------------------------------------
module bdpc_core import bdpc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  bdpc_cfg_t  cfg_regs,
  input  logic       item_valid,
  input  logic       item_level,
  output logic       take,
  bdpc_out_if.source result
);

  // Compare width covers both the counters and the thresholds, so a threshold
  // above the saturated counter value is simply never reached.
  localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

  logic                   previous_level, previous_level_next;
  logic                   settled_level, settled_level_next;
  logic                   held, held_next;
  logic                   long_done, long_done_next;
  logic [COUNT_WIDTH-1:0] settle_count, settle_count_next;
  logic [COUNT_WIDTH-1:0] hold_count, hold_count_next;

  logic                   res_valid;
  logic                   res_pressed;
  logic                   res_short;
  logic                   res_long;

  logic                   short_pulse, long_pulse;
  logic [COUNT_WIDTH-1:0] settle_inc, hold_inc;
  logic                   step;

  assign take = !res_valid || result.ready;
  assign step = take && item_valid;

  // Saturating increments.
  assign settle_inc = (&settle_count) ? settle_count : settle_count + COUNT_WIDTH'(1);
  assign hold_inc   = held ? ((&hold_count) ? hold_count : hold_count + COUNT_WIDTH'(1))
                           : hold_count;

  always_comb begin
    previous_level_next = previous_level;
    settled_level_next  = settled_level;
    held_next           = held;
    long_done_next      = long_done;
    settle_count_next   = settle_count;
    hold_count_next     = hold_inc;
    short_pulse         = 1'b0;
    long_pulse          = 1'b0;

    if (item_level != previous_level) begin
      // A change records the new level and restarts the settle counter.
      previous_level_next = item_level;
      settle_count_next   = '0;
    end else begin
      settle_count_next = settle_inc;
      if ((CMP_W'(settle_inc) >= CMP_W'(cfg_regs.debounce_ticks)) &&
          (settled_level != item_level)) begin
        settled_level_next = item_level;
        if (!item_level) begin
          held_next       = 1'b1;
          hold_count_next = '0;
          long_done_next  = 1'b0;
        end else if (held) begin
          held_next = 1'b0;
          if (!long_done) begin
            if (CMP_W'(hold_inc) >= CMP_W'(cfg_regs.long_press_ticks)) begin
              long_pulse = 1'b1;
            end else begin
              short_pulse = 1'b1;
            end
          end
        end
      end
      if (held_next && !long_done_next &&
          (CMP_W'(hold_count_next) >= CMP_W'(cfg_regs.long_press_ticks))) begin
        long_pulse     = 1'b1;
        long_done_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b1;
      settled_level  <= 1'b1;
      held           <= 1'b0;
      long_done      <= 1'b0;
      settle_count   <= '0;
      hold_count     <= '0;
    end else if (step) begin
      previous_level <= previous_level_next;
      settled_level  <= settled_level_next;
      held           <= held_next;
      long_done      <= long_done_next;
      settle_count   <= settle_count_next;
      hold_count     <= hold_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_pressed <= held_next;
      res_short   <= short_pulse;
      res_long    <= long_pulse;
    end
  end

  assign result.valid       = res_valid;
  assign result.is_pressed  = res_pressed;
  assign result.short_press = res_short;
  assign result.long_press  = res_long;

  // A press is held exactly while the settled level is low.
  a_held_tracks_level: assert property (@(posedge clk) disable iff (rst)
    held == !settled_level)
    else $error("held flag disagrees with settled level");

  // A short press is only reported on release.
  a_short_on_release: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_short |-> !res_pressed)
    else $error("short press reported while still pressed");

  // Short and long pulses never appear in the same result.
  a_pulses_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_short && res_long))
    else $error("short and long press in one result");

  // A long press during a hold marks the hold as already reported.
  a_long_marks_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_long && res_pressed |-> long_done)
    else $error("long press fired without setting the done flag");

endmodule
